FILE: src/aets_pkg.sv
// Package for the audio envelope to servo block: widths, constants, state codes.
// No dependencies.
package aets_pkg;
    localparam int FRAC_BITS_DEF = 24;
    localparam int SAMPLE_W      = 32;
    localparam int LEVEL_W       = 18;
    localparam int CFG_W         = 18;
    localparam int POS_W         = 7;
    localparam int SHIFT_IN      = 14;
    localparam int MEAN_DIV      = 20001;
    localparam int PEAK_DIV      = 2001;
    localparam int POS_FULL      = 100;
    localparam logic [CFG_W-1:0] THRESH_RST = 18'd250;
    localparam logic [CFG_W-1:0] FULL_RST   = 18'd10000;
    localparam int CFG_AW        = 3;
    localparam logic [CFG_AW-1:0] ADDR_THRESH = 3'd0;
    localparam logic [CFG_AW-1:0] ADDR_FULL   = 3'd4;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEAN,
        ST_PEAK,
        ST_SMOOTH,
        ST_MAP,
        ST_OUT
    } core_state_t;
endpackage

FILE: src/aets_if.sv
// Valid/ready channel interfaces for input and result items.
// Depends on aets_pkg.
interface aets_in_if;
    logic                              valid;
    logic                              ready;
    logic                              func;
    logic signed [aets_pkg::SAMPLE_W-1:0] raw_sample;
    modport source (output valid, func, raw_sample, input ready);
    modport sink   (input valid, func, raw_sample, output ready);
endinterface

interface aets_out_if;
    logic                              valid;
    logic                              ready;
    logic [aets_pkg::POS_W-1:0]        servo_position;
    logic [aets_pkg::LEVEL_W-1:0]      envelope_level;
    modport source (output valid, servo_position, envelope_level, input ready);
    modport sink   (input valid, servo_position, envelope_level, output ready);
endinterface

FILE: src/aets_div.sv
// Bit-serial restoring divider: unsigned numerator by unsigned divisor,
// one quotient bit per cycle. Depends on aets_pkg.
module aets_div #(
    parameter int NW = 64,
    parameter int DW = 20
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quot
);
    localparam int CW = $clog2(NW + 1);

    aets_pkg::div_state_t state_reg, state_next;
    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW:0]   trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aets_pkg::DIV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        d_next     = d_reg;
        trial      = {r_reg[DW-1:0], q_reg[NW-1]};
        unique case (state_reg)
            aets_pkg::DIV_IDLE:
            begin
                if (start)
                begin
                    q_next     = num;
                    r_next     = '0;
                    d_next     = den;
                    cnt_next   = CW'(NW);
                    state_next = aets_pkg::DIV_RUN;
                end
            end
            aets_pkg::DIV_RUN:
            begin
                // shift one numerator bit into the remainder, try a subtract
                if (trial >= {1'b0, d_reg})
                begin
                    r_next = trial - {1'b0, d_reg};
                    q_next = {q_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    r_next = trial;
                    q_next = {q_reg[NW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                    state_next = aets_pkg::DIV_DONE;
            end
            aets_pkg::DIV_DONE:
                state_next = aets_pkg::DIV_IDLE;
            default:
                state_next = aets_pkg::DIV_IDLE;
        endcase
    end

    assign done = (state_reg == aets_pkg::DIV_DONE);
    assign quot = q_reg;
endmodule

FILE: src/audio_envelope_to_servo_core.sv
// Top level of the audio envelope to servo block: sequencer, state and APB port.
// Depends on aets_pkg, aets_if and aets_div. Serial dividers, one bit a cycle, NW = FRAC_BITS+27.
// Sequence: a sample runs the mean division and then, unless the peak jumps, the peak decay
//   division before the next accept; a tick runs the smoothing division, then the position division.
//   When no position division is needed, the result is set in the output step.
// Throughput: one item at a time; a waiting result holds a later tick at its output step.
// Reset: rst_n clears state to zero, registers to 250 and 10000.
module audio_envelope_to_servo_core #(
    parameter int FRAC_BITS = aets_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    aets_in_if.sink                     in_ch,
    aets_out_if.source                  out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [aets_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    // State words: integer part of LEVEL_W+1 bits plus fraction.
    localparam int SW  = aets_pkg::LEVEL_W + 1 + FRAC_BITS;
    localparam int NW  = SW + 8;          // numerators carry a bias / factor of 3
    localparam int DW  = 15;              // divisors up to 20001 (also 3)
    localparam int LW  = aets_pkg::LEVEL_W;
    localparam int CW  = aets_pkg::CFG_W;
    // bias exponent: 20001 * 2^MB exceeds any mean difference
    localparam int MB  = SW + 1 - $clog2(aets_pkg::MEAN_DIV);

    // Configuration registers
    logic [CW-1:0] thresh_reg, full_reg;
    logic          wr_en;
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= aets_pkg::THRESH_RST;
            full_reg   <= aets_pkg::FULL_RST;
        end
        else if (wr_en)
        begin
            if (paddr == aets_pkg::ADDR_THRESH)
                thresh_reg <= pwdata[CW-1:0];
            else if (paddr == aets_pkg::ADDR_FULL)
                full_reg <= pwdata[CW-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == aets_pkg::ADDR_THRESH)
            prdata = 32'(thresh_reg);
        else if (paddr == aets_pkg::ADDR_FULL)
            prdata = 32'(full_reg);
    end

    // Filter state
    logic signed [SW-1:0] mean_reg, mean_next;
    logic [SW-1:0]        peak_reg, peak_next;
    logic [SW-1:0]        smooth_reg, smooth_next;
    logic signed [LW-1:0] lvl_reg, lvl_next;
    logic                 func_reg, func_next;
    aets_pkg::core_state_t st_reg, st_next;
    logic                 ovalid_reg, ovalid_next;
    logic [aets_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [LW-1:0]        env_reg, env_next;
    logic                 map_go_reg, map_go_next;

    // Shared serial divider
    logic          div_start, div_done;
    logic [NW-1:0] div_num, div_q;
    logic [DW-1:0] div_den;

    aets_div #(.NW(NW), .DW(DW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    // Separate small serial divider for the position mapping
    localparam int MNW = CW + 7;
    logic           map_start, map_done;
    logic [MNW-1:0] map_num, map_q;
    logic [CW-1:0]  map_den;

    aets_div #(.NW(MNW), .DW(CW)) u_map (
        .clk   (clk),
        .rst_n (rst_n),
        .start (map_start),
        .num   (map_num),
        .den   (map_den),
        .done  (map_done),
        .quot  (map_q)
    );

    // Derived terms
    logic [31:0]           neg_raw;
    logic signed [LW-1:0]  level_in;
    logic signed [SW:0]    diff_mean;
    logic signed [SW:0]    lev_fx;
    logic [SW-1:0]         mean_abs;
    logic signed [LW:0]    mean_int;
    logic signed [LW+1:0]  dev_s;
    logic [LW:0]           dev;
    logic [SW-1:0]         dev_fx;
    logic [NW-1:0]         bias_mean;
    logic [SW-1:0]         ipart_w;
    logic [CW-1:0]         xclamp;
    logic [CW:0]           ipart_sat;

    assign neg_raw  = 32'd0 - in_ch.raw_sample;
    assign level_in = LW'($signed(neg_raw) >>> aets_pkg::SHIFT_IN);
    assign lev_fx   = (SW+1)'($signed(lvl_reg)) <<< FRAC_BITS;
    assign diff_mean = lev_fx - (SW+1)'(mean_reg);
    // floor(n/d) for negative n: add d*2^MB so the numerator stays positive
    assign bias_mean = NW'(aets_pkg::MEAN_DIV) << MB;
    assign mean_abs = mean_reg[SW-1] ? SW'(-mean_reg) : SW'(mean_reg);
    assign mean_int = mean_reg[SW-1] ? -(LW+1)'(mean_abs >> FRAC_BITS)
                                     :  (LW+1)'(mean_abs >> FRAC_BITS);
    assign dev_s    = (LW+2)'(lvl_reg) - (LW+2)'(mean_int);
    assign dev      = dev_s[LW+1] ? (LW+1)'(-dev_s) : (LW+1)'(dev_s);
    assign dev_fx   = SW'(dev) << FRAC_BITS;
    assign ipart_w  = smooth_reg >> FRAC_BITS;
    assign ipart_sat = (ipart_w > SW'({1'b0, {CW{1'b1}}})) ? {1'b0, {CW{1'b1}}}
                                                           : (CW+1)'(ipart_w);

    always_comb
    begin
        xclamp = ipart_sat[CW-1:0];
        if (ipart_sat < (CW+1)'(thresh_reg))
            xclamp = thresh_reg;
        if (ipart_sat > (CW+1)'(full_reg))
            xclamp = full_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= aets_pkg::ST_IDLE;
            mean_reg   <= '0;
            peak_reg   <= '0;
            smooth_reg <= '0;
            ovalid_reg <= 1'b0;
            map_go_reg <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            mean_reg   <= mean_next;
            peak_reg   <= peak_next;
            smooth_reg <= smooth_next;
            ovalid_reg <= ovalid_next;
            map_go_reg <= map_go_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg  <= lvl_next;
        func_reg <= func_next;
        pos_reg  <= pos_next;
        env_reg  <= env_next;
    end

    always_comb
    begin
        st_next     = st_reg;
        mean_next   = mean_reg;
        peak_next   = peak_reg;
        smooth_next = smooth_reg;
        lvl_next    = lvl_reg;
        func_next   = func_reg;
        ovalid_next = ovalid_reg;
        pos_next    = pos_reg;
        env_next    = env_reg;
        map_go_next = map_go_reg;
        div_start   = 1'b0;
        div_num     = '0;
        div_den     = '0;
        map_start   = 1'b0;
        map_num     = MNW'(xclamp - thresh_reg) * MNW'(aets_pkg::POS_FULL);
        map_den     = full_reg - thresh_reg;
        in_ch.ready = 1'b0;

        if (out_ch.valid && out_ch.ready)
            ovalid_next = 1'b0;

        unique case (st_reg)
            aets_pkg::ST_IDLE:
            begin
                // input waits only while a position division is still running
                in_ch.ready = !map_go_reg;
                if (in_ch.valid && !map_go_reg)
                begin
                    lvl_next  = level_in;
                    func_next = in_ch.func;
                    if (in_ch.func)
                    begin
                        st_next   = aets_pkg::ST_SMOOTH;
                        div_start = 1'b1;
                        div_num   = NW'(smooth_reg) * NW'(2) + NW'(peak_reg);
                        div_den   = DW'(3);
                    end
                    else
                        st_next = aets_pkg::ST_MEAN;
                end
            end
            aets_pkg::ST_MEAN:
            begin
                // floor(diff/20001) = (diff + 20001*2^MB)/20001 - 2^MB
                div_start = 1'b1;
                div_num   = bias_mean + NW'(diff_mean);
                div_den   = DW'(aets_pkg::MEAN_DIV);
                st_next   = aets_pkg::ST_PEAK;
            end
            aets_pkg::ST_PEAK:
            begin
                if (div_done)
                begin
                    mean_next = mean_reg + SW'(div_q - (NW'(1) << MB));
                    st_next   = aets_pkg::ST_MAP;
                end
            end
            aets_pkg::ST_MAP:
            begin
                if (!func_reg)
                begin
                    // mean now updated: decide jump or start the decay division
                    if (dev_fx > peak_reg)
                    begin
                        peak_next = dev_fx;
                        st_next   = aets_pkg::ST_IDLE;
                    end
                    else
                    begin
                        div_start = 1'b1;
                        div_num   = NW'(peak_reg - dev_fx) + NW'(aets_pkg::PEAK_DIV - 1);
                        div_den   = DW'(aets_pkg::PEAK_DIV);
                        st_next   = aets_pkg::ST_OUT;
                    end
                end
            end
            aets_pkg::ST_SMOOTH:
            begin
                if (div_done)
                begin
                    smooth_next = SW'(div_q);
                    st_next     = aets_pkg::ST_OUT;
                    func_next   = 1'b1;
                end
            end
            aets_pkg::ST_OUT:
            begin
                if (!func_reg)
                begin
                    if (div_done)
                    begin
                        peak_next = peak_reg - SW'(div_q);
                        st_next   = aets_pkg::ST_IDLE;
                    end
                end
                else if (!ovalid_reg)
                begin
                    // smoothed value ready and output register free: compute command
                    env_next = LW'(ipart_w);
                    if (smooth_reg > (SW'(thresh_reg) << FRAC_BITS))
                    begin
                        if (full_reg <= thresh_reg)
                        begin
                            pos_next    = aets_pkg::POS_W'(aets_pkg::POS_FULL);
                            ovalid_next = 1'b1;
                            st_next     = aets_pkg::ST_IDLE;
                        end
                        else
                        begin
                            map_start   = 1'b1;
                            map_go_next = 1'b1;
                            st_next     = aets_pkg::ST_IDLE;
                        end
                    end
                    else
                    begin
                        pos_next    = '0;
                        ovalid_next = 1'b1;
                        st_next     = aets_pkg::ST_IDLE;
                    end
                end
            end
            default:
                st_next = aets_pkg::ST_IDLE;
        endcase

        // position division completes: publish result
        if (map_go_reg && map_done)
        begin
            pos_next    = aets_pkg::POS_W'(map_q);
            ovalid_next = 1'b1;
            map_go_next = 1'b0;
        end
    end

    assign out_ch.valid          = ovalid_reg;
    assign out_ch.servo_position = pos_reg;
    assign out_ch.envelope_level = env_reg;

    // Checks
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.servo_position <= aets_pkg::POS_W'(aets_pkg::POS_FULL))
        else $error("servo position above full opening");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.servo_position)
            && $stable(out_ch.envelope_level))
        else $error("result dropped while stalled");
    a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> (st_reg == aets_pkg::ST_IDLE) && !map_go_reg)
        else $error("input taken while busy");
endmodule

FILE: sim/tb_aets_if_bfm.sv
// Shared item and result types for the testbench top.
// Depends on aets_pkg.
package tb_aets_types_pkg;
    typedef enum logic {FN_SAMPLE = 1'b0, FN_TICK = 1'b1} item_func_t;
    typedef struct packed {
        logic [aets_pkg::POS_W-1:0]   pos;
        logic [aets_pkg::LEVEL_W-1:0] env;
    } servo_result_t;
endpackage

FILE: sim/tb_audio_envelope_to_servo_core.sv
// Testbench for audio_envelope_to_servo_core: directed table, then random samples and ticks,
// checked against an in-bench envelope predictor. Depends on aets_pkg, aets_if, tb_aets_types_pkg.
module tb_audio_envelope_to_servo_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB        = aets_pkg::FRAC_BITS_DEF;
    localparam int WD_LIMIT  = 20000;
    localparam int DRAIN_CYC = 400;
    localparam tb_aets_types_pkg::item_func_t FS = tb_aets_types_pkg::FN_SAMPLE;
    localparam tb_aets_types_pkg::item_func_t FT = tb_aets_types_pkg::FN_TICK;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [aets_pkg::CFG_AW-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;

    aets_in_if  in_ch();
    aets_out_if out_ch();

    audio_envelope_to_servo_core dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state, 43-bit fixed point held in 64-bit containers
    longint          mean_fx;
    longint unsigned peak_fx;
    longint unsigned smooth_fx;
    longint unsigned thresh_q;
    longint unsigned full_q;

    tb_aets_types_pkg::servo_result_t expected_q[$];
    int  n_fail;
    int  n_ticks_seen;
    int  n_sent;
    int  idle_cycles;
    bit  stim_done;
    bit  hold_off;     // long receiver hold-off, asserted by the stimulus process

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q--;
        return q;
    endfunction

    function automatic longint int_part_trunc(longint v);
        if (v >= 0)
            return v >>> FB;
        return -((-v) >>> FB);
    endfunction

    // sample: negate with 32-bit wrap, floor shift, update mean then peak
    task automatic follow_sample(logic [31:0] raw);
        logic signed [31:0] neg;
        longint lvl, dev;
        longint unsigned dev_fx;
        neg = -raw;
        lvl = floor_div(longint'(neg), longint'(1) << aets_pkg::SHIFT_IN);
        mean_fx = mean_fx + floor_div((lvl <<< FB) - mean_fx, aets_pkg::MEAN_DIV);
        dev = lvl - int_part_trunc(mean_fx);
        if (dev < 0)
            dev = -dev;
        dev_fx = longint'(dev) << FB;
        if (dev_fx > peak_fx)
            peak_fx = dev_fx;
        else
            peak_fx = peak_fx - (peak_fx - dev_fx + (aets_pkg::PEAK_DIV - 1))
                      / aets_pkg::PEAK_DIV;
    endtask

    function automatic tb_aets_types_pkg::servo_result_t smooth_and_map();
        tb_aets_types_pkg::servo_result_t r;
        longint unsigned ip, x, pos;
        smooth_fx = (smooth_fx * 2 + peak_fx) / 3;
        ip = smooth_fx >> FB;
        pos = 0;
        if (smooth_fx > (thresh_q << FB))
        begin
            if (full_q <= thresh_q)
                pos = aets_pkg::POS_FULL;
            else
            begin
                x = ip;
                if (x < thresh_q) x = thresh_q;
                if (x > full_q)   x = full_q;
                pos = (x - thresh_q) * aets_pkg::POS_FULL / (full_q - thresh_q);
            end
        end
        r.pos = pos[aets_pkg::POS_W-1:0];
        r.env = ip[aets_pkg::LEVEL_W-1:0];
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // one input item through the handshake, with a random gap before it
    task automatic send_item(tb_aets_types_pkg::item_func_t fn, logic [31:0] raw);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.func       <= fn;
        in_ch.raw_sample <= raw;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        // accepted at this edge: predict now
        if (fn == tb_aets_types_pkg::FN_SAMPLE)
            follow_sample(raw);
        else
            expected_q.push_back(smooth_and_map());
        n_sent++;
    endtask

    task automatic apb_write(logic [aets_pkg::CFG_AW-1:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == aets_pkg::ADDR_THRESH)
            thresh_q = data[aets_pkg::CFG_W-1:0];
        else
            full_q = data[aets_pkg::CFG_W-1:0];
        @(posedge clk);
    endtask

    // wait until every result is back and the block has had time to finish a sample
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic set_scale(longint unsigned th, longint unsigned fs);
        wait_idle();
        apb_write(aets_pkg::ADDR_THRESH, 32'(th));
        apb_write(aets_pkg::ADDR_FULL, 32'(fs));
    endtask

    // directed rows: func, raw word, whether a result is typed in, and that result
    typedef struct {
        tb_aets_types_pkg::item_func_t    fn;
        logic [31:0]                      raw;
        bit                               typed;
        tb_aets_types_pkg::servo_result_t res;
    } dir_row_t;

    dir_row_t dir_rows[15] = '{
        '{FT, 32'h0,        1'b1, '{7'd0, 18'd0}},   // after reset: all zero
        '{FS, 32'h8000_0000, 1'b0, '{7'd0, 18'd0}},  // most negative word wraps
        '{FS, 32'h7FFF_FFFF, 1'b0, '{7'd0, 18'd0}},  // most positive word
        '{FS, 32'h0,        1'b0, '{7'd0, 18'd0}},
        '{FS, 32'hFFFF_FFFF, 1'b0, '{7'd0, 18'd0}},  // -1: level 0
        '{FS, 32'h0000_4000, 1'b0, '{7'd0, 18'd0}},  // exact shift boundary
        '{FS, 32'h0000_3FFF, 1'b0, '{7'd0, 18'd0}},
        '{FT, 32'hFFFF_FFFF, 1'b0, '{7'd0, 18'd0}},  // raw ignored on tick
        '{FS, 32'h8000_0000, 1'b0, '{7'd0, 18'd0}},
        '{FT, 32'h0,        1'b0, '{7'd0, 18'd0}},
        '{FT, 32'h0,        1'b0, '{7'd0, 18'd0}},
        '{FS, 32'h5555_5555, 1'b0, '{7'd0, 18'd0}},
        '{FS, 32'hAAAA_AAAA, 1'b0, '{7'd0, 18'd0}},
        '{FT, 32'h0,        1'b0, '{7'd0, 18'd0}},
        '{FT, 32'h0,        1'b0, '{7'd0, 18'd0}}
    };

    // random sample word: mostly loud bursts or quiet, sometimes any pattern
    function automatic logic [31:0] rand_raw();
        unique case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            2: return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom())};
            default: return 32'($signed($urandom_range(0, 200000000)) - 100000000);
        endcase
    endfunction

    task automatic random_phase(int n_items, int tick_odds);
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(0, tick_odds) == 0)
                send_item(FT, $urandom());
            else
                send_item(FS, rand_raw());
        end
    endtask

    // stimulus
    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_ch.valid = 1'b0; in_ch.func = 1'b0; in_ch.raw_sample = '0;
        hold_off = 1'b0;
        stim_done = 1'b0;
        n_sent = 0;
        mean_fx = 0; peak_fx = 0; smooth_fx = 0;
        thresh_q = aets_pkg::THRESH_RST; full_q = aets_pkg::FULL_RST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: typed rows overwrite the prediction that send_item pushed
        foreach (dir_rows[k])
        begin
            send_item(dir_rows[k].fn, dir_rows[k].raw);
            if (dir_rows[k].typed)
                expected_q[expected_q.size()-1] = dir_rows[k].res;
        end

        // low threshold, narrow span so positions are either 0 or 100
        set_scale(0, 1);
        random_phase(60, 4);
        // extremes: threshold at top, full scale at top
        set_scale(18'h3FFFF, 18'h3FFFF);
        random_phase(40, 4);
        // inverted scale: anything over threshold gives full opening
        set_scale(50, 10);
        random_phase(100, 4);
        set_scale(5, 300);
        random_phase(200, 3);

        // long receiver hold-off while ticks keep coming
        hold_off = 1'b1;
        random_phase(20, 1);
        hold_off = 1'b0;

        set_scale(aets_pkg::THRESH_RST, aets_pkg::FULL_RST);
        random_phase(200, 5);
        set_scale(0, 18'h3FFFF);
        random_phase(230, 4);
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver with random stalls; long hold-off counted here in cycles
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                out_ch.ready <= 1'b0;
                repeat (600) @(posedge clk);
            end
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 50) : $urandom_range(0, 2);
            if ($urandom_range(0, 3) == 0)
                stall = 0;
            if (stall != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // checker and watchdog
    initial
    begin
        tb_aets_types_pkg::servo_result_t want;
        n_fail = 0;
        n_ticks_seen = 0;
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (out_ch.valid && out_ch.ready)
            begin
                n_ticks_seen++;
                if (expected_q.size() == 0)
                begin
                    n_fail++;
                    $display("%0t: result with none expected: pos %0d env %0d", $time,
                             out_ch.servo_position, out_ch.envelope_level);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (out_ch.servo_position !== want.pos)
                    begin
                        n_fail++;
                        $display("%0t: servo_position expected %0d actual %0d", $time,
                                 want.pos, out_ch.servo_position);
                    end
                    if (out_ch.envelope_level !== want.env)
                    begin
                        n_fail++;
                        $display("%0t: envelope_level expected %0d actual %0d", $time,
                                 want.env, out_ch.envelope_level);
                    end
                end
            end
            if (idle_cycles >= WD_LIMIT)
            begin
                $display("%0t: watchdog, nothing accepted for %0d cycles", $time, WD_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
            if (stim_done && expected_q.size() == 0)
            begin
                repeat (DRAIN_CYC) @(posedge clk);
                if (out_ch.valid || expected_q.size() != 0)
                    n_fail++;
                $display("Run covered %0d input items and %0d results over several scales.",
                         n_sent, n_ticks_seen);
                if (n_fail == 0)
                    $display("PASSED: all results match");
                else
                    $display("FAILED: results differ");
                $finish;
            end
        end
    end
endmodule
